// ----- hdl/bpsra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpsra_pkg
// Shared constants and the fp32 adder function for the bf16 partial-sum block.
// ----------------------------------------------------------------------------
package bpsra_pkg;

	localparam int unsigned MaxPartialsDef = 16;
	localparam int unsigned CountW        = 5;
	localparam logic [31:0] Fp32PosZero   = 32'h0000_0000;
	localparam logic [31:0] Fp32DefNan    = 32'hFFC0_0000;
	localparam logic [31:0] Fp32QuietBit  = 32'h0040_0000;
	localparam logic [0:0]  RegPartialCount = 1'b0;

	function automatic logic [31:0] widen_bf16(input logic [15:0] v);
		return {v, 16'h0000};
	endfunction

	// Number of leading zeros of a 27-bit value (result 0..27).
	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(26 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// IEEE binary32 add, round to nearest even, subnormals kept, x86 NaN rules.
	function automatic logic [31:0] fp32_add(input logic [31:0] a_in, input logic [31:0] b_in);
		logic [31:0] a, b, res;
		logic [7:0]  ea, eb;
		logic [22:0] ma, mb;
		logic [8:0]  ex, ey, d, sh;
		logic [26:0] xa, xb, xbs;
		logic [27:0] s;
		logic [26:0] sn;
		logic [4:0]  lz;
		logic [2:0]  grs;
		logic [24:0] r;
		logic        sign, sticky;
		logic [53:0] wide;
		a = a_in;
		b = b_in;
		ea = a[30:23];
		eb = b[30:23];
		ma = a[22:0];
		mb = b[22:0];
		res = 32'h0;
		if (ea == 8'hFF && ma != 23'h0) begin
			res = a | Fp32QuietBit;
		end else if (eb == 8'hFF && mb != 23'h0) begin
			res = b | Fp32QuietBit;
		end else if (ea == 8'hFF) begin
			res = (eb == 8'hFF && (a[31] ^ b[31])) ? Fp32DefNan : a;
		end else if (eb == 8'hFF) begin
			res = b;
		end else if (a[30:0] == 31'h0 && b[30:0] == 31'h0) begin
			res = a & b;
		end else if (a[30:0] == 31'h0) begin
			res = b;
		end else if (b[30:0] == 31'h0) begin
			res = a;
		end else begin
			if (b[30:0] > a[30:0]) begin
				a = b_in;
				b = a_in;
			end
			ea = a[30:23];
			eb = b[30:23];
			sign = a[31];
			ex = {1'b0, (ea != 8'h0) ? ea : 8'd1};
			ey = {1'b0, (eb != 8'h0) ? eb : 8'd1};
			xa = {(ea != 8'h0), a[22:0], 3'b000};
			xb = {(eb != 8'h0), b[22:0], 3'b000};
			d = ex - ey;
			if (d >= 9'd27) begin
				xbs = {26'h0, (xb != 27'h0)};
			end else begin
				wide = {xb, 27'h0} >> d[4:0];
				sticky = (wide[26:0] != 27'h0);
				xbs = wide[53:27] | {26'h0, sticky};
			end
			if (a[31] == b[31]) begin
				s = {1'b0, xa} + {1'b0, xbs};
				if (s[27]) begin
					sn = s[27:1] | {26'h0, s[0]};
					ex = ex + 9'd1;
				end else begin
					sn = s[26:0];
				end
			end else begin
				s = {1'b0, xa} - {1'b0, xbs};
				sn = s[26:0];
				lz = lzc27(sn);
				// normalize to bit 26, but stop at exponent 1
				sh = ({4'h0, lz} > (ex - 9'd1)) ? (ex - 9'd1) : {4'h0, lz};
				sn = sn << sh[4:0];
				ex = ex - sh;
			end
			if (s == 28'h0) begin
				res = Fp32PosZero;
			end else begin
				grs = sn[2:0];
				r = {1'b0, sn[26:3]};
				if (grs > 3'd4 || (grs == 3'd4 && r[0])) r = r + 25'd1;
				if (r[24]) begin
					r = r >> 1;
					ex = ex + 9'd1;
				end
				if (ex >= 9'd255) res = {sign, 8'hFF, 23'h0};
				else res = {sign, r[23] ? ex[7:0] : 8'h00, r[22:0]};
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/bf16_partial_sum_residual_add.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_partial_sum_residual_add
// Sums groups of bf16 partials in fp32 and adds a bf16 residual per group.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the output is not stalled; a stalled
// result register holds the whole pipe. After the last item of its group is
// taken, a result passes the input register, the accumulate stage and the
// result register in turn. The rate is set by the fp32 accumulator add, which
// feeds back on itself through acc_q; the residual add has a stage of its
// own. partial_count (address 0, low 5 bits stored) sets the group size; 0
// acts as 1 and stored values above MAX_PARTIALS act as MAX_PARTIALS.
module bf16_partial_sum_residual_add #(
	parameter int unsigned MAX_PARTIALS = bpsra_pkg::MaxPartialsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] partial_bits,
	input  wire logic [15:0] attention_bits,
	input  wire logic        last_element,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      sum_bits,
	output logic [31:0]      attention_f32_bits,
	output logic [31:0]      partial_sum_bits,
	output logic             last_out
);
	import bpsra_pkg::*;

	localparam int unsigned IdxW = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

	logic [CountW-1:0] count_q;
	logic [IdxW:0]     eff_count;
	logic [IdxW:0]     idx_q;
	logic [31:0]       acc_q;
	logic              v_s1;
	logic [15:0]       part_s1, att_s1;
	logic              last_s1;
	logic              v_s2;
	logic [31:0]       psum_s2, att_s2;
	logic              last_s2;
	logic              adv;
	logic [31:0]       acc_new, att_w;
	logic              grp_end;

	assign pready = 1'b1;
	assign prdata = (paddr == RegPartialCount) ? {{(32-CountW){1'b0}}, count_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountW'(1);
		end else if (psel && penable && pwrite && paddr == RegPartialCount) begin
			count_q <= pwdata[CountW-1:0];
		end
	end

	always_comb begin
		if (count_q == '0) eff_count = (IdxW+1)'(1);
		else if (32'(count_q) > MAX_PARTIALS) eff_count = (IdxW+1)'(MAX_PARTIALS);
		else eff_count = (IdxW+1)'(count_q);
	end

	// the whole pipe moves unless the result register is held
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			part_s1 <= partial_bits;
			att_s1  <= attention_bits;
			last_s1 <= last_element;
		end
	end

	assign acc_new = fp32_add(acc_q, widen_bf16(part_s1));
	assign att_w   = widen_bf16(att_s1);
	assign grp_end = (32'(idx_q) + 32'd1 >= 32'(eff_count));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= Fp32PosZero;
			idx_q <= '0;
			v_s2  <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && grp_end;
			if (v_s1) begin
				if (grp_end) begin
					acc_q <= Fp32PosZero;
					idx_q <= '0;
				end else begin
					acc_q <= acc_new;
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1 && grp_end) begin
			psum_s2 <= acc_new;
			att_s2  <= att_w;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s2;
		end
	end

	// residual add: attention is the first operand
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			sum_bits           <= fp32_add(att_s2, psum_s2);
			attention_f32_bits <= att_s2;
			partial_sum_bits   <= psum_s2;
			last_out           <= last_s2;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) < MAX_PARTIALS)
		else $error("partial index out of range");
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result without a staged item");
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && grp_end) |=> (acc_q == Fp32PosZero && idx_q == '0))
		else $error("accumulator not cleared at group end");

endmodule
`default_nettype wire

// ----- verif/bf16_partial_sum_residual_add_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_partial_sum_residual_add_tb
// Streams bf16 partials through the block under several group sizes, each
// set over the register port while idle, and compares every result element
// with a bit-exact fp32 accumulation predictor.
// ----------------------------------------------------------------------------

class bf16_reduce_scoreboard;
	bit [31:0] acc;
	int unsigned group_pos;
	bit [4:0] count_reg;
	bit [96:0] expected_q[$];
	int unsigned mismatches;
	int unsigned matched;

	function new();
		acc = 32'h0;
		group_pos = 0;
		count_reg = 5'd1;
		mismatches = 0;
		matched = 0;
	endfunction

	// IEEE binary32 add, nearest even, subnormals kept, x86 NaN selection
	function bit [31:0] fadd(bit [31:0] a, bit [31:0] b);
		bit [31:0] t, sign, ex, ey, xa, xb, s, d;
		bit [7:0] ea, eb;
		bit [22:0] ma, mb;
		ea = a[30:23];
		eb = b[30:23];
		ma = a[22:0];
		mb = b[22:0];
		if (ea == 8'hFF && ma != 0) return a | 32'h0040_0000;
		if (eb == 8'hFF && mb != 0) return b | 32'h0040_0000;
		if (ea == 8'hFF) begin
			if (eb == 8'hFF && a[31] != b[31]) return 32'hFFC0_0000;
			return a;
		end
		if (eb == 8'hFF) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return a & b;
		if (a[30:0] == 0) return b;
		if (b[30:0] == 0) return a;
		if (b[30:0] > a[30:0]) begin
			t = a;
			a = b;
			b = t;
		end
		ea = a[30:23];
		eb = b[30:23];
		sign = {a[31], 31'h0};
		ex = (ea != 0) ? ea : 1;
		ey = (eb != 0) ? eb : 1;
		xa = {(ea != 0), a[22:0]} << 3;
		xb = {(eb != 0), b[22:0]} << 3;
		d = ex - ey;
		if (d >= 27) xb = (xb != 0);
		else if (d > 0) xb = (xb >> d) | ((xb & ((32'h1 << d) - 1)) != 0);
		if (a[31] == b[31]) begin
			s = xa + xb;
			if (s >= (32'h1 << 27)) begin
				s = (s >> 1) | (s & 1);
				ex++;
			end
		end else begin
			s = xa - xb;
			if (s == 0) return 32'h0;
			while (s < (32'h1 << 26) && ex > 1) begin
				s <<= 1;
				ex--;
			end
		end
		d = s & 7;
		s >>= 3;
		if (d > 4 || (d == 4 && s[0])) s++;
		if (s >= (32'h1 << 24)) begin
			s >>= 1;
			ex++;
		end
		if (ex >= 255) return sign | 32'h7F80_0000;
		return sign | (((s >= (32'h1 << 23)) ? ex : 0) << 23) | (s & 32'h7F_FFFF);
	endfunction

	function void note_transfer(bit [15:0] partial, bit [15:0] att, bit last);
		int unsigned eff;
		bit [31:0] attw;
		eff = (count_reg == 0) ? 1 : (count_reg > 16) ? 16 : count_reg;
		acc = fadd(acc, {partial, 16'h0});
		if (group_pos + 1 < eff) begin
			group_pos++;
			return;
		end
		attw = {att, 16'h0};
		expected_q.push_back({fadd(attw, acc), attw, acc, last});
		acc = 32'h0;
		group_pos = 0;
	endfunction

	function void check_result(bit [31:0] sum, bit [31:0] att, bit [31:0] psum, bit last);
		bit [96:0] e;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result sum=%h att=%h psum=%h last=%b", sum, att, psum, last);
			return;
		end
		e = expected_q.pop_front();
		if (e != {sum, att, psum, last}) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: exp sum=%h att=%h psum=%h last=%b, got %h %h %h %b",
					e[96:65], e[64:33], e[32:1], e[0], sum, att, psum, last);
		end else begin
			matched++;
		end
	endfunction
endclass

module bf16_partial_sum_residual_add_tb;
	import bpsra_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] partial_bits = '0, attention_bits = '0;
	logic last_element = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] sum_bits, attention_f32_bits, partial_sum_bits;
	logic last_out;

	bf16_reduce_scoreboard board = new();
	bit stall_stream_on = 1'b1;
	int unsigned groups_run = 0;

	bf16_partial_sum_residual_add u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sink side: check each transfer and draw random stalls
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(sum_bits, attention_f32_bits, partial_sum_bits, last_out);
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (stall_stream_on && $urandom_range(0, 3) == 0) begin
				stall_left <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_count(bit [31:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= RegPartialCount;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.count_reg = value[4:0];
	endtask

	// valid stays high into the next item when no gap is drawn
	task automatic send_item(bit [15:0] p, bit [15:0] a, bit l, bit gaps);
		int unsigned gap;
		gap = gaps ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		partial_bits <= p;
		attention_bits <= a;
		last_element <= l;
		do @(posedge clk); while (in_stall);
		board.note_transfer(p, a, l);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly normal-range values, with specials and random raw patterns
	function automatic bit [15:0] rand_bf16();
		case ($urandom_range(0, 9))
			0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 7'($urandom_range(0, 127))};
			1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h00, 7'($urandom_range(0, 127))};
			2, 3: return 16'($urandom);
			default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
				8'($urandom_range(120, 134)), 7'($urandom_range(0, 127))};
		endcase
	endfunction

	task automatic run_phase(bit [31:0] count, int unsigned n);
		drain();
		write_count(count);
		for (int i = 0; i < n; i++) begin
			send_item(rand_bf16(), rand_bf16(), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) != 0);
			if (i == n / 2) drain();
		end
		groups_run++;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: specials under the reset group size of one
		send_item(16'h0000, 16'h0000, 1'b0, 1'b0);
		send_item(16'h8000, 16'h8000, 1'b1, 1'b0);
		send_item(16'h7F80, 16'hFF80, 1'b0, 1'b0);
		send_item(16'h7FC1, 16'hFF81, 1'b1, 1'b0);
		send_item(16'h0001, 16'h8001, 1'b0, 1'b0);
		send_item(16'h7F7F, 16'h7F7F, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0000, 1'b0, 1'b0);
		send_item(16'h3F80, 16'hBF80, 1'b1, 1'b0);
		drain();
		write_count(32'd2);
		send_item(16'h7F80, 16'h3F80, 1'b0, 1'b0);
		send_item(16'hFF80, 16'h3F80, 1'b1, 1'b0);
		send_item(16'h8000, 16'h8000, 1'b0, 1'b0);
		send_item(16'h8000, 16'h8000, 1'b1, 1'b0);
		send_item(16'h3F80, 16'h3380, 1'b0, 1'b0);
		// count changed mid-group: accumulated state carries over
		drain();
		write_count(32'd0);
		send_item(16'h4000, 16'h0000, 1'b1, 1'b0);
		drain();
		write_count(32'd31);
		for (int i = 0; i < 16; i++) send_item(16'h7F7F, 16'h7F7F, 1'b0, 1'b0);
		// random phases across group sizes, extremes included
		run_phase(32'd1, 150);
		run_phase(32'd16, 200);
		run_phase(32'd3, 150);
		run_phase(32'd0, 100);
		run_phase(32'd17, 100);
		run_phase(32'hFFFF_FFE5, 100);
		run_phase(32'd2, 150);
		run_phase(32'd7, 150);
		stall_stream_on = 1'b0;
		run_phase(32'd4, 100);
		stall_stream_on = 1'b1;
		run_phase(32'd5, 120);
		drain();
		$display("Ran %0d random phases plus directed specials; %0d results matched.",
			groups_run, board.matched);
		if (board.mismatches == 0 && board.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end
endmodule
